>>> rtl/core/pop3_flow_classifier_unit_defines.svh
// Assertion macros for the POP3 flow classifier.
// Each macro expects clk and rst in scope at the point of use.
`ifndef POP3_FLOW_CLASSIFIER_UNIT_DEFINES_SVH
`define POP3_FLOW_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define POP3FC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define POP3FC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pop3fc_pkg.sv
// Shared types, constants and match helpers for the POP3 flow classifier.
// No dependencies.
package pop3fc_pkg;

  localparam int unsigned NUM_CMDS = 11;
  localparam int unsigned CLS_DEPTH = 4;   // power of two: pointers wrap
  localparam int unsigned CLS_PTR_W = $clog2(CLS_DEPTH);
  localparam int unsigned CLS_CNT_W = $clog2(CLS_DEPTH + 1);
  localparam int unsigned RES_DEPTH = 2;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [7:0]  SPLIT_LIMIT_RESET = 8'd12;
  localparam logic [4:0]  ID_THRESH_RESET   = 5'd3;
  localparam logic [15:0] CRLF_WORD         = 16'h0d0a;
  localparam logic [7:0]  RESP_MAX          = 8'hff;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_K     = 8'h6b;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_R     = 8'h72;

  // configuration register indexes
  localparam logic CFG_SPLIT_LIMIT = 1'b0;
  localparam logic CFG_ID_THRESH   = 1'b1;

  // lower-case client commands, index is the mask bit, first letter in [31:24]
  localparam logic [31:0] CMD_TABLE [NUM_CMDS] = '{
    "auth", "apop", "user", "pass", "capa", "list",
    "stat", "uidl", "retr", "dele", "stls"
  };

  typedef enum logic [2:0] {
    VERDICT_IDLE       = 3'd0,
    VERDICT_CONTINUE   = 3'd1,
    VERDICT_IDENTIFIED = 3'd2,
    VERDICT_SPLIT      = 3'd3,
    VERDICT_EXCLUDED   = 3'd4
  } verdict_t;

  // classified packet, front to back
  typedef struct packed {
    logic                flow_start;
    logic                is_resp;
    logic [NUM_CMDS-1:0] cmd_hit;   // one-hot or zero
    logic                crlf;
    logic                young;     // packet_count below split limit
  } cls_t;

  typedef struct packed {
    verdict_t            verdict;
    logic [NUM_CMDS-1:0] command_mask;
    logic [7:0]          response_count;
  } res_t;

  // flow state seen from the top level
  typedef struct packed {
    logic [NUM_CMDS-1:0] seen;
    logic [3:0]          cmd_count;
    logic                excluded;
    logic                identified;
  } flow_status_t;

  // letter match in either case; lower must be a lower-case letter
  function automatic logic letter_is(input logic [7:0] b, input logic [7:0] lower);
    return (b | 8'h20) == lower;
  endfunction

endpackage

>>> rtl/core/pop3_flow_classifier_unit.sv
// Top level of the POP3 flow classifier: config registers, front, queue, back.
// Depends on pop3fc_pkg, pop3fc_front, pop3fc_cls_queue, pop3fc_back and the defines header.
//
// One packet summary enters per cycle unless full, and one result leaves per cycle unless empty.
// A packet is matched combinationally on the push side and written into a four-entry queue;
// the back end reads one entry per cycle while the result buffer has room or is being popped,
// updates the flow state and writes the verdict into a two-entry result buffer, so a result
// passes through the queue entry and then the result buffer before it is visible. Throughput
// is set by the flow state update loop in the back end. Config writes must happen only while
// no packet is in flight; the split limit is applied as packets are pushed.
`include "pop3_flow_classifier_unit_defines.svh"

module pop3_flow_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        flow_start,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [7:0]  tail_hi,
  input  logic [7:0]  tail_lo,
  input  logic [15:0] payload_len,
  input  logic [15:0] packet_count,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  verdict,
  output logic [10:0] command_mask,
  output logic [7:0]  response_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0]                 split_limit;
  logic [4:0]                 id_thresh;
  pop3fc_pkg::cls_t           front_item;
  pop3fc_pkg::cls_t           queue_item;
  logic                       queue_valid;
  logic                       queue_take;
  pop3fc_pkg::res_t           res_item;
  pop3fc_pkg::flow_status_t   status;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_limit <= pop3fc_pkg::SPLIT_LIMIT_RESET;
      id_thresh   <= pop3fc_pkg::ID_THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pop3fc_pkg::CFG_SPLIT_LIMIT: split_limit <= cfg_data;
        pop3fc_pkg::CFG_ID_THRESH:   id_thresh   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  pop3fc_front u_front (
    .flow_start   (flow_start),
    .byte0        (byte0),
    .byte1        (byte1),
    .byte2        (byte2),
    .byte3        (byte3),
    .tail_hi      (tail_hi),
    .tail_lo      (tail_lo),
    .payload_len  (payload_len),
    .packet_count (packet_count),
    .split_limit  (split_limit),
    .item         (front_item)
  );

  pop3fc_cls_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (queue_take),
    .valid   (queue_valid),
    .rd_item (queue_item)
  );

  pop3fc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (queue_valid),
    .cls_item  (queue_item),
    .cls_take  (queue_take),
    .id_thresh (id_thresh),
    .res_pop   (pop),
    .res_empty (empty),
    .res_item  (res_item),
    .status    (status)
  );

  assign verdict        = res_item.verdict;
  assign command_mask   = res_item.command_mask;
  assign response_count = res_item.response_count;

  `POP3FC_ASSERT_NOW(a_one_decision, 1'b1, !(status.excluded && status.identified), "flow both excluded and identified")
  `POP3FC_ASSERT_NOW(a_cmd_count, 1'b1, status.cmd_count == 4'($countones(status.seen)), "command count out of step with mask")
  `POP3FC_ASSERT_NOW(a_ident_has_resp, !empty && verdict == pop3fc_pkg::VERDICT_IDENTIFIED, response_count != 8'd0, "identified without a response")

endmodule

>>> rtl/core/pop3fc_front.sv
// Front end: matches responses, client commands and the CR LF ending of one packet.
// Depends on pop3fc_pkg.
module pop3fc_front (
  input  logic              flow_start,
  input  logic [7:0]        byte0,
  input  logic [7:0]        byte1,
  input  logic [7:0]        byte2,
  input  logic [7:0]        byte3,
  input  logic [7:0]        tail_hi,
  input  logic [7:0]        tail_lo,
  input  logic [15:0]       payload_len,
  input  logic [15:0]       packet_count,
  input  logic [7:0]        split_limit,
  output pop3fc_pkg::cls_t  item
);

  logic                                is_ok;
  logic                                is_err;
  logic                                len_gt2;
  logic                                len_gt3;
  logic                                len_gt4;
  logic [pop3fc_pkg::NUM_CMDS-1:0]     hit;

  assign len_gt2 = payload_len > 16'd2;
  assign len_gt3 = payload_len > 16'd3;
  assign len_gt4 = payload_len > 16'd4;

  assign is_ok = len_gt3 && (byte0 == pop3fc_pkg::CH_PLUS) &&
                 pop3fc_pkg::letter_is(byte1, pop3fc_pkg::CH_O) &&
                 pop3fc_pkg::letter_is(byte2, pop3fc_pkg::CH_K);

  assign is_err = len_gt4 && (byte0 == pop3fc_pkg::CH_MINUS) &&
                  pop3fc_pkg::letter_is(byte1, pop3fc_pkg::CH_E) &&
                  pop3fc_pkg::letter_is(byte2, pop3fc_pkg::CH_R) &&
                  pop3fc_pkg::letter_is(byte3, pop3fc_pkg::CH_R);

  // commands are distinct words, so at most one entry hits
  for (genvar i = 0; i < pop3fc_pkg::NUM_CMDS; i++) begin : g_cmd
    assign hit[i] = pop3fc_pkg::letter_is(byte0, pop3fc_pkg::CMD_TABLE[i][31:24]) &&
                    pop3fc_pkg::letter_is(byte1, pop3fc_pkg::CMD_TABLE[i][23:16]) &&
                    pop3fc_pkg::letter_is(byte2, pop3fc_pkg::CMD_TABLE[i][15:8]) &&
                    pop3fc_pkg::letter_is(byte3, pop3fc_pkg::CMD_TABLE[i][7:0]);
  end

  always_comb begin
    item.flow_start = flow_start;
    item.is_resp    = is_ok || is_err;
    item.cmd_hit    = (len_gt4 && !(is_ok || is_err)) ? hit : '0;
    item.crlf       = len_gt2 && ({tail_hi, tail_lo} == pop3fc_pkg::CRLF_WORD);
    item.young      = packet_count < {8'd0, split_limit};
  end

endmodule

>>> rtl/core/pop3fc_cls_queue.sv
// Short queue of classified packets between the front and back ends.
// Depends on pop3fc_pkg.
module pop3fc_cls_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  pop3fc_pkg::cls_t  wr_item,
  output logic              full,
  input  logic              rd_en,
  output logic              valid,
  output pop3fc_pkg::cls_t  rd_item
);

  pop3fc_pkg::cls_t                  entries [pop3fc_pkg::CLS_DEPTH];
  logic [pop3fc_pkg::CLS_PTR_W-1:0]  wr_ptr;
  logic [pop3fc_pkg::CLS_PTR_W-1:0]  rd_ptr;
  logic [pop3fc_pkg::CLS_CNT_W-1:0]  count;
  logic                              do_wr;
  logic                              do_rd;

  assign full  = count == pop3fc_pkg::CLS_CNT_W'(pop3fc_pkg::CLS_DEPTH);
  assign valid = count != '0;
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && valid;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_item;
  end

endmodule

>>> rtl/core/pop3fc_back.sv
// Back end: holds the flow state, decides the verdict and buffers results.
// Depends on pop3fc_pkg.
module pop3fc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cls_valid,
  input  pop3fc_pkg::cls_t          cls_item,
  output logic                      cls_take,
  input  logic [4:0]                id_thresh,
  input  logic                      res_pop,
  output logic                      res_empty,
  output pop3fc_pkg::res_t          res_item,
  output pop3fc_pkg::flow_status_t  status
);

  logic [pop3fc_pkg::NUM_CMDS-1:0]   seen;
  logic [pop3fc_pkg::NUM_CMDS-1:0]   seen_next;
  logic [3:0]                        cmd_count;
  logic [3:0]                        cmd_count_next;
  logic [7:0]                        responses;
  logic [7:0]                        responses_next;
  logic                              excluded;
  logic                              excluded_next;
  logic                              identified;
  logic                              identified_next;
  pop3fc_pkg::verdict_t              verdict;

  logic [pop3fc_pkg::NUM_CMDS-1:0]   seen_base;
  logic [3:0]                        cnt_base;
  logic [7:0]                        resp_base;
  logic                              excl_base;
  logic                              ident_base;
  logic                              matched;
  logic [8:0]                        evidence;

  pop3fc_pkg::res_t                  res_buf [pop3fc_pkg::RES_DEPTH];
  logic [pop3fc_pkg::RES_PTR_W-1:0]  res_wr_ptr;
  logic [pop3fc_pkg::RES_PTR_W-1:0]  res_rd_ptr;
  logic [pop3fc_pkg::RES_CNT_W-1:0]  res_count;
  logic                              res_full;
  logic                              do_pop;

  assign res_full  = res_count == pop3fc_pkg::RES_CNT_W'(pop3fc_pkg::RES_DEPTH);
  assign res_empty = res_count == '0;
  assign do_pop    = res_pop && !res_empty;
  // a slot frees up when the oldest result leaves this cycle
  assign cls_take  = cls_valid && (!res_full || do_pop);
  assign res_item  = res_buf[res_rd_ptr];

  always_comb begin
    seen_base  = cls_item.flow_start ? '0   : seen;
    cnt_base   = cls_item.flow_start ? '0   : cmd_count;
    resp_base  = cls_item.flow_start ? '0   : responses;
    excl_base  = cls_item.flow_start ? 1'b0 : excluded;
    ident_base = cls_item.flow_start ? 1'b0 : identified;

    seen_next       = seen_base;
    cmd_count_next  = cnt_base;
    responses_next  = resp_base;
    excluded_next   = excl_base;
    identified_next = ident_base;
    verdict         = pop3fc_pkg::VERDICT_IDLE;
    matched         = cls_item.is_resp || (cls_item.cmd_hit != '0);
    evidence        = '0;

    if (!excl_base && !ident_base) begin
      if (cls_item.is_resp && resp_base != pop3fc_pkg::RESP_MAX) begin
        responses_next = resp_base + 1'b1;
      end
      seen_next      = seen_base | cls_item.cmd_hit;
      cmd_count_next = cnt_base + 4'(|(cls_item.cmd_hit & ~seen_base));
      evidence       = {5'd0, cmd_count_next} + {1'b0, responses_next};

      priority if (matched) begin
        if (cls_item.crlf && responses_next != '0 && evidence >= {4'd0, id_thresh}) begin
          identified_next = 1'b1;
          verdict         = pop3fc_pkg::VERDICT_IDENTIFIED;
        end else begin
          verdict = pop3fc_pkg::VERDICT_CONTINUE;
        end
      end else if ((cls_item.crlf || seen_base != '0 || resp_base != '0) &&
                   cls_item.young) begin
        verdict = pop3fc_pkg::VERDICT_SPLIT;
      end else begin
        excluded_next = 1'b1;
        verdict       = pop3fc_pkg::VERDICT_EXCLUDED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= '0;
      cmd_count  <= '0;
      responses  <= '0;
      excluded   <= 1'b0;
      identified <= 1'b0;
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (cls_take) begin
        seen       <= seen_next;
        cmd_count  <= cmd_count_next;
        responses  <= responses_next;
        excluded   <= excluded_next;
        identified <= identified_next;
        res_wr_ptr <= res_wr_ptr + 1'b1;
      end
      if (do_pop) res_rd_ptr <= res_rd_ptr + 1'b1;
      unique case ({cls_take, do_pop})
        2'b10:   res_count <= res_count + 1'b1;
        2'b01:   res_count <= res_count - 1'b1;
        default: res_count <= res_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cls_take) begin
      res_buf[res_wr_ptr] <= '{verdict: verdict, command_mask: seen_next,
                               response_count: responses_next};
    end
  end

  always_comb begin
    status.seen       = seen;
    status.cmd_count  = cmd_count;
    status.excluded   = excluded;
    status.identified = identified;
  end

endmodule
